>>> rtl/bed_pkg.sv
package bed_pkg;

   localparam int BUTTON_COUNT = 3;
   localparam int BTN_W        = $clog2(BUTTON_COUNT);
   localparam int PIN_W        = 3;
   localparam int TIME_W       = 32;
   localparam int MS_W         = 16;
   localparam int MASK_W       = 3;
   localparam int KIND_W       = 3;
   localparam int IDX_W        = 2;

   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   localparam int QUEUE_DEPTH  = 2;

   // Repeat divisor: floor(x / 200) = floor((x >> 3) * 10486 >> 18) for x below 2^16.
   localparam int RAMP_STEP_MS     = 200;
   localparam int RAMP_PRE_SHIFT   = 3;
   localparam int RAMP_RECIP       = 10486;
   localparam int RAMP_RECIP_SHIFT = 18;
   localparam int RAMP_PROD_W      = 27;
   localparam int Q_W              = $clog2(((1 << MS_W) - 1) / RAMP_STEP_MS + 1);
   localparam int MOD_IDX_W        = $clog2(TIME_W);

   localparam logic [MS_W-1:0]   POLL_RESET   = 16'd20;
   localparam logic [MASK_W-1:0] MASK_RESET   = 3'd0;
   localparam logic [MS_W-1:0]   DELAY_RESET  = 16'd300;
   localparam logic [MS_W-1:0]   LONG_RESET   = 16'd1800;
   localparam logic [MS_W-1:0]   RAMP_RESET   = 16'd2000;

   typedef enum logic [2:0] {
      REG_POLL  = 3'd0,
      REG_MASK  = 3'd1,
      REG_DELAY = 3'd2,
      REG_LONG  = 3'd3,
      REG_RAMP  = 3'd4
   } reg_index_type;

   typedef enum logic [KIND_W-1:0] {
      EV_PRESS   = 3'd0,
      EV_RELEASE = 3'd1,
      EV_CLICK   = 3'd2,
      EV_LONG    = 3'd3,
      EV_REPEAT  = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [MS_W-1:0]   poll_interval_ms;
      logic [MASK_W-1:0] repeat_enable_mask;
      logic [MS_W-1:0]   repeat_start_delay_ms;
      logic [MS_W-1:0]   long_press_ms;
      logic [MS_W-1:0]   repeat_ramp_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [PIN_W-1:0]  pin_levels;
   } sample_type;

endpackage

>>> rtl/bed_if.sv
interface bed_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [2:0]  pin_levels;

   modport source (output valid, now_ms, pin_levels, input ready);
   modport sink (input valid, now_ms, pin_levels, output ready);
endinterface

interface bed_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] button_index;
   logic [2:0] event_kind;
   logic       last_event;

   modport source (output valid, button_index, event_kind, last_event, input ready);
   modport sink (input valid, button_index, event_kind, last_event, output ready);
endinterface

>>> rtl/bed_csr.sv
module bed_csr
   import bed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_POLL:  cfg_in.poll_interval_ms      = pwdata[MS_W-1:0];
            REG_MASK:  cfg_in.repeat_enable_mask    = pwdata[MASK_W-1:0];
            REG_DELAY: cfg_in.repeat_start_delay_ms = pwdata[MS_W-1:0];
            REG_LONG:  cfg_in.long_press_ms         = pwdata[MS_W-1:0];
            REG_RAMP:  cfg_in.repeat_ramp_ms        = pwdata[MS_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_POLL:  prdata = {{(CSR_DATA_W-MS_W){1'b0}}, cfg_ff.poll_interval_ms};
         REG_MASK:  prdata = {{(CSR_DATA_W-MASK_W){1'b0}}, cfg_ff.repeat_enable_mask};
         REG_DELAY: prdata = {{(CSR_DATA_W-MS_W){1'b0}}, cfg_ff.repeat_start_delay_ms};
         REG_LONG:  prdata = {{(CSR_DATA_W-MS_W){1'b0}}, cfg_ff.long_press_ms};
         REG_RAMP:  prdata = {{(CSR_DATA_W-MS_W){1'b0}}, cfg_ff.repeat_ramp_ms};
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_interval_ms      <= POLL_RESET;
         cfg_ff.repeat_enable_mask    <= MASK_RESET;
         cfg_ff.repeat_start_delay_ms <= DELAY_RESET;
         cfg_ff.long_press_ms         <= LONG_RESET;
         cfg_ff.repeat_ramp_ms        <= RAMP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/bed_front.sv
module bed_front
   import bed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   bed_req_if.sink    req,
   input  logic       can_push,
   output logic       push,
   output sample_type push_data
);

   logic [TIME_W-1:0] last_poll_ff;
   logic [TIME_W-1:0] last_poll_in;
   logic [TIME_W-1:0] poll_due;
   logic              accept;
   logic              acted;

   // The sum wraps; a sample that does not pass the unsigned compare is dropped.
   assign poll_due  = last_poll_ff + {{(TIME_W-MS_W){1'b0}}, cfg.poll_interval_ms};
   assign acted     = req.now_ms > poll_due;
   assign req.ready = can_push;
   assign accept    = req.valid && can_push;
   assign push      = accept && acted;

   assign push_data.now_ms     = req.now_ms;
   assign push_data.pin_levels = req.pin_levels;

   assign last_poll_in = push ? req.now_ms : last_poll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_poll_ff <= '0;
      end else begin
         last_poll_ff <= last_poll_in;
      end
   end

endmodule

>>> rtl/bed_queue.sv
module bed_queue
   import bed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sample_type push_data,
   output logic       can_push,
   input  logic       pop,
   output sample_type head,
   output logic       head_valid
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sample_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign can_push   = count_ff != CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/bed_back.sv
module bed_back
   import bed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  sample_type head,
   input  logic       head_valid,
   output logic       pop,
   bed_rsp_if.source  rsp
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_EVAL  = 8'b0000_0010,
      S_CLICK = 8'b0000_0100,
      S_RAMP  = 8'b0000_1000,
      S_QUOT  = 8'b0001_0000,
      S_MOD   = 8'b0010_0000,
      S_REP   = 8'b0100_0000,
      S_FLUSH = 8'b1000_0000
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [BTN_W-1:0]     btn_ff, btn_in;
   logic [PIN_W-1:0]     pressed_ff, pressed_in;
   logic [TIME_W-1:0]    hold_ff, hold_in;
   logic [TIME_W-1:0]    rep_cnt_ff, rep_cnt_in;
   logic                 handled_ff, handled_in;

   logic [TIME_W-1:0]    hold_time_ff, hold_time_in;
   logic [MS_W-1:0]      q_raw_ff, q_raw_in;
   logic [Q_W-1:0]       q_ff, q_in;
   logic [Q_W-1:0]       rem_ff, rem_in;
   logic [MOD_IDX_W-1:0] bit_idx_ff, bit_idx_in;

   logic                 pend_valid_ff, pend_valid_in;
   logic [BTN_W-1:0]     pend_btn_ff, pend_btn_in;
   event_kind_type       pend_kind_ff, pend_kind_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_btn_ff, rsp_btn_in;
   event_kind_type       rsp_kind_ff, rsp_kind_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 level_down;
   logic                 state_down;
   logic                 in_mask;
   logic                 last_btn;
   logic [TIME_W-1:0]    hold_time;
   logic                 repeat_due;
   logic                 long_due;
   logic [TIME_W-1:0]    ramp_used;
   logic [RAMP_PROD_W-1:0] ramp_prod;
   logic [Q_W-1:0]       ramp_quo;
   logic [Q_W:0]         rem_shift;
   logic                 out_free;
   logic                 emit_ok;
   logic                 emit;
   event_kind_type       emit_kind;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.button_index = rsp_btn_ff;
   assign rsp.event_kind   = rsp_kind_ff;
   assign rsp.last_event   = rsp_last_ff;

   assign level_down = !head.pin_levels[btn_ff];
   assign state_down = pressed_ff[btn_ff];
   assign in_mask    = cfg.repeat_enable_mask[btn_ff];
   assign last_btn   = btn_ff == BTN_W'(BUTTON_COUNT - 1);

   // Hold time is read as signed; a negative one never fires.
   assign hold_time  = head.now_ms - hold_ff;
   assign repeat_due = !hold_time[TIME_W-1] &&
      (hold_time[TIME_W-2:0] > {{(TIME_W-1-MS_W){1'b0}}, cfg.repeat_start_delay_ms});
   assign long_due   = !hold_time[TIME_W-1] &&
      (hold_time[TIME_W-2:0] > {{(TIME_W-1-MS_W){1'b0}}, cfg.long_press_ms});

   assign ramp_used = hold_time_ff - {{(TIME_W-MS_W){1'b0}}, cfg.repeat_start_delay_ms};
   assign ramp_prod = RAMP_PROD_W'(q_raw_ff >> RAMP_PRE_SHIFT) * RAMP_PROD_W'(RAMP_RECIP);
   assign ramp_quo  = Q_W'(ramp_prod >> RAMP_RECIP_SHIFT);
   assign rem_shift = {rem_ff, rep_cnt_ff[bit_idx_ff]};

   // An event parks in the pending slot so that the last one of a sample can be flagged.
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit_ok  = !pend_valid_ff || out_free;

   always_comb begin
      state_in      = state_ff;
      btn_in        = btn_ff;
      pressed_in    = pressed_ff;
      hold_in       = hold_ff;
      rep_cnt_in    = rep_cnt_ff;
      handled_in    = handled_ff;
      hold_time_in  = hold_time_ff;
      q_raw_in      = q_raw_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      bit_idx_in    = bit_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_btn_in   = pend_btn_ff;
      pend_kind_in  = pend_kind_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_btn_in    = rsp_btn_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      emit          = 1'b0;
      emit_kind     = EV_PRESS;
      pop           = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               btn_in   = '0;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            hold_time_in = hold_time;
            if (level_down != state_down) begin
               emit      = 1'b1;
               emit_kind = level_down ? EV_PRESS : EV_RELEASE;
               if (emit_ok) begin
                  pressed_in[btn_ff] = level_down;
                  rep_cnt_in         = '0;
                  if (level_down) begin
                     hold_in = head.now_ms;
                  end else begin
                     hold_in    = '0;
                     handled_in = 1'b0;
                  end
                  if (!level_down && !handled_ff) begin
                     state_in = S_CLICK;
                  end else begin
                     state_in = last_btn ? S_FLUSH : S_EVAL;
                     btn_in   = btn_ff + BTN_W'(1);
                  end
               end
            end else if (level_down && in_mask && repeat_due) begin
               state_in = S_RAMP;
            end else if (level_down && !in_mask && !handled_ff && long_due) begin
               emit      = 1'b1;
               emit_kind = EV_LONG;
               if (emit_ok) begin
                  hold_in    = '0;
                  rep_cnt_in = '0;
                  handled_in = 1'b1;
                  state_in   = last_btn ? S_FLUSH : S_EVAL;
                  btn_in     = btn_ff + BTN_W'(1);
               end
            end else begin
               state_in = last_btn ? S_FLUSH : S_EVAL;
               btn_in   = btn_ff + BTN_W'(1);
            end
         end
         S_CLICK: begin
            emit      = 1'b1;
            emit_kind = EV_CLICK;
            if (emit_ok) begin
               state_in = last_btn ? S_FLUSH : S_EVAL;
               btn_in   = btn_ff + BTN_W'(1);
            end
         end
         S_RAMP: begin
            // Ramp remainder, clamped at zero.
            if (ramp_used < {{(TIME_W-MS_W){1'b0}}, cfg.repeat_ramp_ms}) begin
               q_raw_in = cfg.repeat_ramp_ms - ramp_used[MS_W-1:0];
            end else begin
               q_raw_in = '0;
            end
            state_in = S_QUOT;
         end
         S_QUOT: begin
            q_in       = (ramp_quo == '0) ? Q_W'(1) : ramp_quo;
            rem_in     = '0;
            bit_idx_in = MOD_IDX_W'(TIME_W - 1);
            state_in   = S_MOD;
         end
         S_MOD: begin
            // One restoring step of repeat_counter mod q per cycle, MSB first.
            if (rem_shift >= {1'b0, q_ff}) begin
               rem_in = Q_W'(rem_shift - {1'b0, q_ff});
            end else begin
               rem_in = rem_shift[Q_W-1:0];
            end
            if (bit_idx_ff == '0) begin
               state_in = S_REP;
            end else begin
               bit_idx_in = bit_idx_ff - MOD_IDX_W'(1);
            end
         end
         S_REP: begin
            emit      = rem_ff == '0;
            emit_kind = EV_REPEAT;
            if (!emit || emit_ok) begin
               rep_cnt_in = rep_cnt_ff + TIME_W'(1);
               state_in   = last_btn ? S_FLUSH : S_EVAL;
               btn_in     = btn_ff + BTN_W'(1);
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               pop      = 1'b1;
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_btn_in    = IDX_W'(pend_btn_ff);
               rsp_kind_in   = pend_kind_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               pop           = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit && emit_ok) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_btn_in   = IDX_W'(pend_btn_ff);
            rsp_kind_in  = pend_kind_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_btn_in   = btn_ff;
         pend_kind_in  = emit_kind;
      end
   end

   always_ff @(posedge clock) begin
      hold_time_ff <= hold_time_in;
      q_raw_ff     <= q_raw_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      bit_idx_ff   <= bit_idx_in;
      pend_btn_ff  <= pend_btn_in;
      pend_kind_ff <= pend_kind_in;
      rsp_btn_ff   <= rsp_btn_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         btn_ff        <= '0;
         pressed_ff    <= '0;
         hold_ff       <= '0;
         rep_cnt_ff    <= '0;
         handled_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         btn_ff        <= btn_in;
         pressed_ff    <= pressed_in;
         hold_ff       <= hold_in;
         rep_cnt_ff    <= rep_cnt_in;
         handled_ff    <= handled_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending item left over after a sample finished");

   a_mod_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> (q_ff != '0 && rem_ff < q_ff))
      else $error("repeat remainder out of range");

   a_pop_at_flush: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_FLUSH && head_valid))
      else $error("sample popped outside flush or from an empty queue");

endmodule

>>> rtl/button_event_detector.sv
// The last item of a sample is registered to the output in the flush state, after every
// button is evaluated; each earlier item is registered once the next event of the same
// sample is found and the output is free. Per acted-on sample the back end passes idle, an
// evaluation per button, click per click, ramp, quotient, mod and repeat per held repeating
// button past its delay, and flush; the queue takes new samples meanwhile until it is full.
// Reset is synchronous and active high: registers return to defaults, state clears.
module button_event_detector
   import bed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bed_req_if.sink               req_ch,
   bed_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   logic       can_push;
   logic       push;
   sample_type push_data;
   logic       pop;
   sample_type head;
   logic       head_valid;

   bed_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bed_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_ch),
      .can_push  (can_push),
      .push      (push),
      .push_data (push_data)
   );

   bed_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .can_push   (can_push),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   bed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

>>> bench/button_event_detector_tb.sv
`timescale 1ns / 1ps

module button_event_detector_tb;
   import bed_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 400;
   localparam int ITEMS_PER_MIX = 41;
   localparam int UNTYPED       = -1;

   typedef struct packed {
      logic [IDX_W-1:0] button_index;
      event_kind_type   event_kind;
      logic             last_event;
   } button_event_type;

   typedef struct {
      logic              is_write;
      reg_index_type     reg_index;
      logic [31:0]       data;
      logic [PIN_W-1:0]  pins;
      int                typed_count;
      button_event_type  typed[3];
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bed_req_if req_if();
   bed_rsp_if rsp_if();

   button_event_detector u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor copy of the detector's settings and state.
   cfg_type           det_cfg;
   logic [PIN_W-1:0]  det_pressed;
   logic [TIME_W-1:0] det_last_poll;
   logic [TIME_W-1:0] det_hold_start;
   logic [TIME_W-1:0] det_repeat_count;
   logic              det_handled;

   button_event_type expected_events[$];
   button_event_type sample_events[$];
   button_event_type next_event;
   stim_row_type     stim_table[$];

   int send_idle_pct;
   int take_idle_pct;
   int errors;
   int cycle_count;
   int events_checked;
   int samples_sent;
   int samples_acted;
   int writes_done;

   always #4 clock = ~clock;

   function automatic button_event_type evt(int b, event_kind_type k, logic last);
      button_event_type e;
      e.button_index = IDX_W'(b);
      e.event_kind   = k;
      e.last_event   = last;
      return e;
   endfunction

   function automatic stim_row_type sample_row(logic [31:0] now, logic [PIN_W-1:0] pins,
                                               int typed_count = UNTYPED,
                                               button_event_type e0 = '0,
                                               button_event_type e1 = '0,
                                               button_event_type e2 = '0);
      stim_row_type row;
      row.is_write    = 1'b0;
      row.reg_index   = REG_POLL;
      row.data        = now;
      row.pins        = pins;
      row.typed_count = typed_count;
      row.typed[0]    = e0;
      row.typed[1]    = e1;
      row.typed[2]    = e2;
      return row;
   endfunction

   function automatic stim_row_type write_row(reg_index_type idx, logic [31:0] value);
      stim_row_type row;
      row = sample_row(value, '1);
      row.is_write  = 1'b1;
      row.reg_index = idx;
      return row;
   endfunction

   // Register value with random upper bits; the field itself hits its extremes now and then.
   function automatic logic [31:0] pick_ms(int lo, int hi);
      logic [31:0] value;
      int          roll;
      value = $urandom;
      roll  = $urandom_range(0, 7);
      if (roll == 0)
         value[MS_W-1:0] = MS_W'(lo);
      else if (roll == 1)
         value[MS_W-1:0] = '1;
      else
         value[MS_W-1:0] = MS_W'($urandom_range(lo, hi));
      return value;
   endfunction

   // Works out the events one sample causes and leaves them in sample_events.
   task automatic predict_sample(input logic [31:0] now, input logic [PIN_W-1:0] pins,
                                 output logic acted);
      logic [31:0]        threshold;
      logic signed [31:0] held;
      longint             divisor;
      logic               was_down;
      logic               is_down;
      button_event_type   tail;
      sample_events.delete();
      acted     = 1'b0;
      threshold = det_last_poll + det_cfg.poll_interval_ms;
      if (now <= threshold)
         return;
      acted         = 1'b1;
      det_last_poll = now;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         was_down = det_pressed[b];
         is_down  = !pins[b];
         if (is_down != was_down) begin
            det_hold_start   = now;
            det_repeat_count = '0;
            if (is_down) begin
               det_pressed[b] = 1'b1;
               sample_events.push_back(evt(b, EV_PRESS, 1'b0));
            end else begin
               det_pressed[b] = 1'b0;
               sample_events.push_back(evt(b, EV_RELEASE, 1'b0));
               if (!det_handled)
                  sample_events.push_back(evt(b, EV_CLICK, 1'b0));
               det_hold_start   = '0;
               det_repeat_count = '0;
               det_handled      = 1'b0;
            end
         end else if (is_down) begin
            held = now - det_hold_start;
            if (det_cfg.repeat_enable_mask[b]) begin
               if (longint'(held) > longint'(det_cfg.repeat_start_delay_ms)) begin
                  divisor = longint'(det_cfg.repeat_ramp_ms) -
                            (longint'(held) - longint'(det_cfg.repeat_start_delay_ms));
                  if (divisor < 0)
                     divisor = 0;
                  divisor = divisor / RAMP_STEP_MS;
                  if (divisor == 0)
                     divisor = 1;
                  if ((longint'(det_repeat_count) % divisor) == 0)
                     sample_events.push_back(evt(b, EV_REPEAT, 1'b0));
                  det_repeat_count = det_repeat_count + 1;
               end
            end else if (!det_handled &&
                         longint'(held) > longint'(det_cfg.long_press_ms)) begin
               det_hold_start   = '0;
               det_repeat_count = '0;
               det_handled      = 1'b1;
               sample_events.push_back(evt(b, EV_LONG, 1'b0));
            end
         end
      end
      if (sample_events.size() > 0) begin
         tail            = sample_events.pop_back();
         tail.last_event = 1'b1;
         sample_events.push_back(tail);
      end
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      case (idx)
         REG_POLL:  det_cfg.poll_interval_ms      = value[MS_W-1:0];
         REG_MASK:  det_cfg.repeat_enable_mask    = value[MASK_W-1:0];
         REG_DELAY: det_cfg.repeat_start_delay_ms = value[MS_W-1:0];
         REG_LONG:  det_cfg.long_press_ms         = value[MS_W-1:0];
         REG_RAMP:  det_cfg.repeat_ramp_ms        = value[MS_W-1:0];
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Returns at the rising edge where the sample item is taken.
   task automatic send_sample(input logic [31:0] now, input logic [PIN_W-1:0] pins);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.now_ms     <= now;
      req_if.pin_levels <= pins;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      samples_sent++;
   endtask

   // Drops valid and waits until the detector has nothing left to report.
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic build_table();
      // Samples at or below the poll threshold are dropped.
      stim_table.push_back(sample_row(32'd0, 3'b111, 0));
      stim_table.push_back(sample_row(32'd20, 3'b000, 0));
      stim_table.push_back(sample_row(32'd21, 3'b110, 1, evt(0, EV_PRESS, 1'b1)));
      stim_table.push_back(sample_row(32'd100, 3'b110, 0));
      stim_table.push_back(sample_row(32'd1000, 3'b111, 2, evt(0, EV_RELEASE, 1'b0),
                                      evt(0, EV_CLICK, 1'b1)));
      stim_table.push_back(sample_row(32'd1100, 3'b000, 3, evt(0, EV_PRESS, 1'b0),
                                      evt(1, EV_PRESS, 1'b0), evt(2, EV_PRESS, 1'b1)));
      // The long click sets the shared handled flag, which holds off the other held buttons.
      stim_table.push_back(sample_row(32'd3000, 3'b000, 1, evt(0, EV_LONG, 1'b1)));
      stim_table.push_back(sample_row(32'd3100, 3'b001, 2, evt(0, EV_RELEASE, 1'b0),
                                      evt(1, EV_LONG, 1'b1)));
      stim_table.push_back(sample_row(32'd3200, 3'b111, 3, evt(1, EV_RELEASE, 1'b0),
                                      evt(2, EV_RELEASE, 1'b0), evt(2, EV_CLICK, 1'b1)));
      stim_table.push_back(write_row(REG_MASK, 32'hFFFF_FFFF));
      stim_table.push_back(sample_row(32'd4000, 3'b110));
      stim_table.push_back(sample_row(32'd4200, 3'b110));
      stim_table.push_back(sample_row(32'd4400, 3'b110));
      stim_table.push_back(sample_row(32'd4421, 3'b110));
      stim_table.push_back(write_row(REG_POLL, 32'hABCD_0000));
      stim_table.push_back(write_row(REG_DELAY, 32'hFFFF_0000));
      stim_table.push_back(write_row(REG_RAMP, 32'h1234_0000));
      stim_table.push_back(sample_row(32'd4422, 3'b110));
      stim_table.push_back(sample_row(32'd4423, 3'b110));
      // A hold time past 2^31 reads as negative and fires nothing.
      stim_table.push_back(sample_row(32'h8000_1000, 3'b110, 0));
      stim_table.push_back(sample_row(32'hFFFF_FFFF, 3'b111, 2, evt(0, EV_RELEASE, 1'b0),
                                      evt(0, EV_CLICK, 1'b1)));
      // The poll threshold sum wraps past 2^32.
      stim_table.push_back(write_row(REG_POLL, 32'h0000_FFFF));
      stim_table.push_back(sample_row(32'd5, 3'b000, 0));
      stim_table.push_back(sample_row(32'h0001_0000, 3'b011, 1, evt(2, EV_PRESS, 1'b1)));
      stim_table.push_back(write_row(REG_MASK, 32'h0000_0000));
      stim_table.push_back(write_row(REG_LONG, 32'h5555_0000));
      stim_table.push_back(sample_row(32'h0002_0000, 3'b011, 1, evt(2, EV_LONG, 1'b1)));
      stim_table.push_back(write_row(REG_LONG, 32'h0000_FFFF));
      stim_table.push_back(sample_row(32'h0003_0000, 3'b111, 1, evt(2, EV_RELEASE, 1'b1)));
   endtask

   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(0, 99) >= take_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: expected no event, actual button %0d kind %0d last %0d",
                     $time, rsp_if.button_index, rsp_if.event_kind, rsp_if.last_event);
         end else begin
            next_event = expected_events.pop_front();
            events_checked++;
            if (rsp_if.button_index !== next_event.button_index ||
                rsp_if.event_kind !== next_event.event_kind ||
                rsp_if.last_event !== next_event.last_event) begin
               errors++;
               $display("%0t: expected button %0d kind %0d last %0d, actual %0d %0d %0d",
                        $time, next_event.button_index, next_event.event_kind,
                        next_event.last_event, rsp_if.button_index, rsp_if.event_kind,
                        rsp_if.last_event);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d events outstanding",
                  cycle_count, expected_events.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [31:0]      threshold;
      logic [31:0]      now_val;
      logic [PIN_W-1:0] pins_val;
      logic [PIN_W-1:0] held_pins;
      longint           candidate;
      int               roll;
      int               acted_count;
      logic             acted;

      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_if.valid      = 1'b0;
      req_if.now_ms     = '0;
      req_if.pin_levels = '1;
      rsp_if.ready      = 1'b0;
      errors            = 0;
      cycle_count       = 0;
      events_checked    = 0;
      samples_sent      = 0;
      samples_acted     = 0;
      writes_done       = 0;
      send_idle_pct     = 38;
      take_idle_pct     = 62;
      det_cfg           = '{POLL_RESET, MASK_RESET, DELAY_RESET, LONG_RESET, RAMP_RESET};
      det_pressed       = '0;
      det_last_poll     = '0;
      det_hold_start    = '0;
      det_repeat_count  = '0;
      det_handled       = 1'b0;
      held_pins         = '1;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      build_table();
      foreach (stim_table[r]) begin
         if (stim_table[r].is_write) begin
            settle();
            csr_write(stim_table[r].reg_index, stim_table[r].data);
         end else begin
            send_sample(stim_table[r].data, stim_table[r].pins);
            predict_sample(stim_table[r].data, stim_table[r].pins, acted);
            if (acted)
               samples_acted++;
            if (stim_table[r].typed_count == UNTYPED) begin
               foreach (sample_events[k])
                  expected_events.push_back(sample_events[k]);
            end else begin
               for (int k = 0; k < stim_table[r].typed_count; k++)
                  expected_events.push_back(stim_table[r].typed[k]);
            end
         end
      end

      for (int mix = 0; mix < 3; mix++) begin
         settle();
         send_idle_pct = (mix == 0) ? 38 : (mix == 1) ? 62 : 0;
         take_idle_pct = (mix == 0) ? 62 : (mix == 1) ? 38 : 0;
         // The poll interval never goes to zero here so the time base cannot get stuck at the top.
         csr_write(REG_POLL, pick_ms(1, 30));
         csr_write(REG_MASK, $urandom);
         csr_write(REG_DELAY, pick_ms(0, 400));
         csr_write(REG_LONG, pick_ms(0, 2000));
         csr_write(REG_RAMP, pick_ms(0, 2500));
         acted_count = 0;
         while (acted_count < ITEMS_PER_MIX) begin
            threshold = det_last_poll + det_cfg.poll_interval_ms;
            roll      = $urandom_range(0, 99);
            if (roll < 10) begin
               // Noise: a stale time that the detector drops, with random pins.
               now_val  = 32'($urandom % (longint'(threshold) + 1));
               pins_val = PIN_W'($urandom);
            end else begin
               if (roll < 12)
                  candidate = longint'(threshold) +
                              longint'($urandom_range(32'h7FFF_0000, 32'h8001_0000));
               else if (roll < 16)
                  candidate = longint'(threshold) + longint'($urandom_range(500, 5000));
               else
                  candidate = longint'(threshold) + longint'($urandom_range(1, 60));
               // Near the top of the time range jump straight to the last value so it wraps.
               if (candidate > longint'(32'hFFFE_FFFF))
                  candidate = longint'(32'hFFFF_FFFF);
               now_val = 32'(candidate);
               for (int b = 0; b < PIN_W; b++)
                  if ($urandom_range(0, 9) == 0)
                     held_pins[b] = ~held_pins[b];
               pins_val = held_pins;
            end
            send_sample(now_val, pins_val);
            predict_sample(now_val, pins_val, acted);
            foreach (sample_events[k])
               expected_events.push_back(sample_events[k]);
            if (acted) begin
               samples_acted++;
               acted_count++;
            end
         end
      end

      settle();
      $display("Sent %0d samples, %0d acted on, under three idle mixes.",
               samples_sent, samples_acted);
      $display("Checked %0d events across %0d register writes.", events_checked, writes_done);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> button_event_detector.f
rtl/bed_pkg.sv
rtl/bed_if.sv
rtl/bed_csr.sv
rtl/bed_front.sv
rtl/bed_queue.sv
rtl/bed_back.sv
rtl/button_event_detector.sv
bench/button_event_detector_tb.sv
